// File: rtl/core/vafd_pkg.sv
`default_nettype none
package vafd_pkg;

    // register indexes on the config port
    localparam logic [2:0] REG_CLASS      = 3'd0;
    localparam logic [2:0] REG_COMP_TYPE  = 3'd1;
    localparam logic [2:0] REG_COLOR_FMT  = 3'd2;
    localparam logic [2:0] REG_COMP_COUNT = 3'd3;
    localparam logic [2:0] REG_OUT_COMPS  = 3'd4;
    localparam logic [2:0] REG_FRAC_BITS  = 3'd5;
    localparam logic [2:0] REG_LITTLE_END = 3'd6;

    localparam logic [2:0] TYPE_U8  = 3'd0;
    localparam logic [2:0] TYPE_S8  = 3'd1;
    localparam logic [2:0] TYPE_U16 = 3'd2;
    localparam logic [2:0] TYPE_S16 = 3'd3;
    localparam logic [2:0] TYPE_F32 = 3'd4;

    localparam logic [2:0] FMT_RGB565 = 3'd0;
    localparam logic [2:0] FMT_RGB8   = 3'd1;
    localparam logic [2:0] FMT_RGBX8  = 3'd2;
    localparam logic [2:0] FMT_RGBA4  = 3'd3;
    localparam logic [2:0] FMT_RGBA6  = 3'd4;

    localparam logic [1:0] SEL_255 = 2'd0;
    localparam logic [1:0] SEL_63  = 2'd1;
    localparam logic [1:0] SEL_31  = 2'd2;
    localparam logic [1:0] SEL_15  = 2'd3;

    localparam logic [31:0] FLOAT_ONE = 32'h3F80_0000;

    typedef enum logic [1:0] {
        KIND_RAW   = 2'd0,
        KIND_INT   = 2'd1,
        KIND_COLOR = 2'd2
    } comp_kind_t;

    // INT: data[15:0] magnitude; COLOR: data[7:0] channel, data[9:8] table select
    typedef struct packed {
        comp_kind_t  kind;
        logic        sign;
        logic [3:0]  msb;
        logic [31:0] data;
    } comp_t;

    typedef logic [31:0] ftab_t [256];

    // correctly rounded single v/m for 0 <= v <= m, by restoring compare-subtract
    function automatic logic [31:0] unit_div(input int v, input int m);
        int n;
        int e;
        int q;
        logic [7:0] eb;
        if (v == 0)
            return 32'd0;
        if (v >= m)
            return FLOAT_ONE;
        n = v;
        e = 127;
        for (int k = 0; k < 8; k++)
        begin
            if (n < m)
            begin
                n = n * 2;
                e = e - 1;
            end
        end
        q = 0;
        for (int k = 0; k < 24; k++)
        begin
            q = q * 2;
            if (n >= m)
            begin
                q = q + 1;
                n = n - m;
            end
            n = n * 2;
        end
        if (n > m || (n == m && q[0]))
            q = q + 1;
        if (q == 32'h0100_0000)
        begin
            q = 32'h0080_0000;
            e = e + 1;
        end
        eb = 8'(e);
        return {1'b0, eb, q[22:0]};
    endfunction

    function automatic ftab_t build_tab(input int m);
        ftab_t t;
        for (int i = 0; i < 256; i++)
            t[i] = (i <= m) ? unit_div(i, m) : 32'd0;
        return t;
    endfunction

    localparam ftab_t TAB_255 = build_tab(255);
    localparam ftab_t TAB_63  = build_tab(63);
    localparam ftab_t TAB_31  = build_tab(31);
    localparam ftab_t TAB_15  = build_tab(15);

endpackage
`default_nettype wire

// File: rtl/core/vertex_attribute_format_decoder.sv
// Vertex attribute format decoder.
// Slave stream s_axis_*: one beat is one fetched attribute record of twelve
// bytes (tdata) with its batch marker (tlast). Master stream m_axis_*: one
// beat per record with four IEEE single components, written_count and tlast.
// Config port: cfg_we with cfg_index/cfg_wdata writes one register per cycle;
// write only while the pipeline is empty.
// Throughput: one beat per cycle while m_axis is not stalled; the three
// register stages (field unpack, leading-one search and color table
// lookup, float assembly) each take one beat every cycle unless held.
// Each stage holds its beat while the next is full, so a stall on m_axis
// backs up stage by stage and s_axis_tready drops only when all three are
// occupied; nothing is dropped or repeated.
// Reset empties the pipeline and loads the register defaults: numeric class,
// u8, rgb565, three source and three destination components, no fraction
// bits, big-endian.
`default_nettype none
module vertex_attribute_format_decoder (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [4:0]   cfg_wdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [95:0]  s_axis_tdata,   // record_low[63:0], record_high[95:64]
    input  wire logic         s_axis_tlast,   // last_record
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // value_0[31:0], value_1[63:32], value_2[95:64], value_3[127:96],
    // written_count[130:128], zero pad [135:131]
    output logic [135:0]      m_axis_tdata,
    output logic              m_axis_tlast    // last_result
);

    logic       class_reg;
    logic [2:0] type_reg;
    logic [2:0] fmt_reg;
    logic [1:0] count_reg;
    logic [1:0] outc_reg;
    logic [4:0] frac_reg;
    logic       le_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_reg <= 1'b0;
            type_reg  <= vafd_pkg::TYPE_U8;
            fmt_reg   <= vafd_pkg::FMT_RGB565;
            count_reg <= 2'd3;
            outc_reg  <= 2'd3;
            frac_reg  <= 5'd0;
            le_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vafd_pkg::REG_CLASS:      class_reg <= cfg_wdata[0];
                vafd_pkg::REG_COMP_TYPE:  type_reg  <= cfg_wdata[2:0];
                vafd_pkg::REG_COLOR_FMT:  fmt_reg   <= cfg_wdata[2:0];
                vafd_pkg::REG_COMP_COUNT: count_reg <= cfg_wdata[1:0];
                vafd_pkg::REG_OUT_COMPS:  outc_reg  <= cfg_wdata[1:0];
                vafd_pkg::REG_FRAC_BITS:  frac_reg  <= cfg_wdata[4:0];
                vafd_pkg::REG_LITTLE_END: le_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // pipeline flow control
    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;
    assign en3 = !v3_reg || m_axis_tready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_axis_tready = en1;

    // ---------------- stage 1: field unpack ----------------
    logic [7:0]         rb [12];
    vafd_pkg::comp_t    c1_next [4];
    logic [2:0]         wc1_next;
    logic [15:0]        w16 [3];
    logic [31:0]        w32 [3];
    logic [15:0]        cw16;
    logic [23:0]        cw24;
    logic [1:0]         comps;
    logic [2:0]         ntype;
    logic signed [16:0] sval;

    always_comb
    begin
        for (int k = 0; k < 8; k++)
            rb[k] = s_axis_tdata[8*k +: 8];
        for (int k = 0; k < 4; k++)
            rb[8+k] = s_axis_tdata[64 + 8*k +: 8];
        for (int j = 0; j < 3; j++)
        begin
            w16[j] = le_reg ? {rb[2*j+1], rb[2*j]} : {rb[2*j], rb[2*j+1]};
            w32[j] = le_reg ? {rb[4*j+3], rb[4*j+2], rb[4*j+1], rb[4*j]}
                            : {rb[4*j], rb[4*j+1], rb[4*j+2], rb[4*j+3]};
        end
        cw16 = w16[0];
        cw24 = le_reg ? {rb[2], rb[1], rb[0]} : {rb[0], rb[1], rb[2]};
        comps = (count_reg == 2'd0) ? 2'd3 : count_reg;
        ntype = (type_reg > vafd_pkg::TYPE_F32) ? vafd_pkg::TYPE_U8 : type_reg;
        sval = '0;

        for (int j = 0; j < 4; j++)
        begin
            c1_next[j].kind = vafd_pkg::KIND_RAW;
            c1_next[j].sign = 1'b0;
            c1_next[j].msb  = 4'd0;
            c1_next[j].data = 32'd0;
        end

        if (class_reg)
        begin
            wc1_next = 3'd4;
            for (int j = 0; j < 4; j++)
                c1_next[j].kind = vafd_pkg::KIND_COLOR;
            case (fmt_reg)
                vafd_pkg::FMT_RGB565:
                begin
                    c1_next[0].data = {22'd0, vafd_pkg::SEL_31, 3'd0, cw16[15:11]};
                    c1_next[1].data = {22'd0, vafd_pkg::SEL_63, 2'd0, cw16[10:5]};
                    c1_next[2].data = {22'd0, vafd_pkg::SEL_31, 3'd0, cw16[4:0]};
                    c1_next[3].data = {22'd0, vafd_pkg::SEL_255, 8'd255};
                end
                vafd_pkg::FMT_RGBA4:
                begin
                    for (int j = 0; j < 4; j++)
                        c1_next[j].data = {22'd0, vafd_pkg::SEL_15, 4'd0,
                                           cw16[4*(3-j) +: 4]};
                end
                vafd_pkg::FMT_RGBA6:
                begin
                    for (int j = 0; j < 4; j++)
                        c1_next[j].data = {22'd0, vafd_pkg::SEL_63, 2'd0,
                                           cw24[6*(3-j) +: 6]};
                end
                default:
                begin
                    for (int j = 0; j < 4; j++)
                        c1_next[j].data = {22'd0, vafd_pkg::SEL_255, rb[j]};
                    if (fmt_reg == vafd_pkg::FMT_RGB8 || fmt_reg == vafd_pkg::FMT_RGBX8)
                        c1_next[3].data = {22'd0, vafd_pkg::SEL_255, 8'd255};
                end
            endcase
        end
        else
        begin
            wc1_next = (comps > outc_reg) ? {1'b0, comps} : {1'b0, outc_reg};
            for (int j = 0; j < 3; j++)
            begin
                if (2'(j) < comps)
                begin
                    case (ntype)
                        vafd_pkg::TYPE_S8:  sval = 17'(signed'(rb[j]));
                        vafd_pkg::TYPE_U16: sval = {1'b0, w16[j]};
                        vafd_pkg::TYPE_S16: sval = 17'(signed'(w16[j]));
                        default:            sval = {9'd0, rb[j]};
                    endcase
                    if (ntype == vafd_pkg::TYPE_F32)
                        c1_next[j].data = w32[j];
                    else
                    begin
                        c1_next[j].kind = vafd_pkg::KIND_INT;
                        c1_next[j].sign = sval[16];
                        c1_next[j].data = {16'd0, sval[16] ? 16'(-sval) : sval[15:0]};
                    end
                end
            end
        end
    end

    vafd_pkg::comp_t c1_reg [4];
    logic [2:0]      wc1_reg;
    logic [4:0]      fb1_reg;
    logic            l1_reg;

    // ---------------- stage 2: msb search, color table ----------------
    vafd_pkg::comp_t c2_next [4];
    logic [7:0]      cv;

    always_comb
    begin
        cv = '0;
        for (int j = 0; j < 4; j++)
        begin
            c2_next[j] = c1_reg[j];
            cv = c1_reg[j].data[7:0];
            case (c1_reg[j].kind)
                vafd_pkg::KIND_INT:
                begin
                    for (int i = 0; i < 16; i++)
                        if (c1_reg[j].data[i])
                            c2_next[j].msb = 4'(i);
                end
                vafd_pkg::KIND_COLOR:
                begin
                    c2_next[j].kind = vafd_pkg::KIND_RAW;
                    case (c1_reg[j].data[9:8])
                        vafd_pkg::SEL_63:  c2_next[j].data = vafd_pkg::TAB_63[cv];
                        vafd_pkg::SEL_31:  c2_next[j].data = vafd_pkg::TAB_31[cv];
                        vafd_pkg::SEL_15:  c2_next[j].data = vafd_pkg::TAB_15[cv];
                        default:           c2_next[j].data = vafd_pkg::TAB_255[cv];
                    endcase
                end
                default: ;
            endcase
        end
    end

    vafd_pkg::comp_t c2_reg [4];
    logic [2:0]      wc2_reg;
    logic [4:0]      fb2_reg;
    logic            l2_reg;

    // ---------------- stage 3: float assembly ----------------
    logic [31:0] f3_next [4];
    logic [7:0]  ex;
    logic [15:0] nm;

    always_comb
    begin
        ex = '0;
        nm = '0;
        for (int j = 0; j < 4; j++)
        begin
            // value is mag * 2^-frac, exact in single
            nm = c2_reg[j].data[15:0] << (4'd15 - c2_reg[j].msb);
            ex = 8'd127 + {4'd0, c2_reg[j].msb} - {3'd0, fb2_reg};
            if (c2_reg[j].kind != vafd_pkg::KIND_INT)
                f3_next[j] = c2_reg[j].data;
            else if (c2_reg[j].data[15:0] == 16'd0)
                f3_next[j] = 32'd0;
            else
                f3_next[j] = {c2_reg[j].sign, ex, nm[14:0], 8'd0};
        end
    end

    logic [31:0] f3_reg [4];
    logic [2:0]  wc3_reg;
    logic        l3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= s_axis_tvalid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            c1_reg  <= c1_next;
            wc1_reg <= wc1_next;
            fb1_reg <= frac_reg;
            l1_reg  <= s_axis_tlast;
        end
        if (en2)
        begin
            c2_reg  <= c2_next;
            wc2_reg <= wc1_reg;
            fb2_reg <= fb1_reg;
            l2_reg  <= l1_reg;
        end
        if (en3)
        begin
            f3_reg  <= f3_next;
            wc3_reg <= wc2_reg;
            l3_reg  <= l2_reg;
        end
    end

    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = {5'd0, wc3_reg, f3_reg[3], f3_reg[2], f3_reg[1], f3_reg[0]};
    assign m_axis_tlast  = l3_reg;

endmodule
`default_nettype wire

// File: tb/sv/vafd_checker.sv
`timescale 1ns / 1ps
module vafd_checker
    import vafd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [4:0]   cfg_wdata,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic [95:0]  s_axis_tdata,
    input  wire logic         s_axis_tlast,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [135:0] m_axis_tdata,
    input  wire logic         m_axis_tlast,
    output int                pending,
    output int                failures
);

    typedef struct {
        logic [31:0] comp [4];
        logic [2:0]  count;
        logic        last;
    } vertex_out_t;

    vertex_out_t expected_q [$];

    logic       m_class;
    logic [2:0] m_type;
    logic [2:0] m_fmt;
    logic [1:0] m_count;
    logic [1:0] m_outc;
    logic [4:0] m_frac;
    logic       m_le;

    function automatic logic [7:0] rbyte(logic [95:0] rec, int k);
        return rec[8*k +: 8];
    endfunction

    function automatic logic [31:0] rword(logic [95:0] rec, int pos, int n, logic le);
        logic [31:0] w;
        w = '0;
        for (int k = 0; k < n; k++)
            w |= 32'(rbyte(rec, pos + k)) << (8 * (le ? k : n - 1 - k));
        return w;
    endfunction

    // exact: |iv| < 2^17, scale is a power of two
    function automatic logic [31:0] int_to_float(int iv, int fb);
        logic       sgn;
        int         mag;
        int         p;
        logic [31:0] sh;
        if (iv == 0)
            return 32'd0;
        sgn = iv < 0;
        mag = sgn ? -iv : iv;
        p = 0;
        for (int b = 0; b < 31; b++)
            if (mag >> b != 0)
                p = b;
        sh = 32'(mag) << (23 - p);
        return {sgn, 8'(127 + p - fb), sh[22:0]};
    endfunction

    // v/m rounded to nearest even, 0 <= v <= m
    function automatic logic [31:0] ratio_float(int v, int m);
        int      s;
        longint  num;
        longint  q;
        longint  r;
        int      e;
        if (v == 0)
            return 32'd0;
        if (v >= m)
            return FLOAT_ONE;
        s = 0;
        while ((longint'(v) << s) < m)
            s++;
        num = longint'(v) << (s + 23);
        q = num / m;
        r = num % m;
        e = 127 - s;
        if (2 * r > m || (2 * r == m && q[0]))
            q++;
        if (q == (64'd1 << 24))
        begin
            q = 64'd1 << 23;
            e++;
        end
        return {1'b0, 8'(e), q[22:0]};
    endfunction

    function automatic vertex_out_t decode_vertex(logic [95:0] rec, logic last);
        vertex_out_t o;
        int          comps;
        int          outc;
        logic [2:0]  ty;
        logic [31:0] w;
        int          iv;
        int          bits;
        int          mask;
        for (int j = 0; j < 4; j++)
            o.comp[j] = '0;
        o.last = last;
        if (m_class)
        begin
            o.count = 3'd4;
            if (m_fmt == FMT_RGB565)
            begin
                w = rword(rec, 0, 2, m_le);
                o.comp[0] = ratio_float((w >> 11) & 31, 31);
                o.comp[1] = ratio_float((w >> 5) & 63, 63);
                o.comp[2] = ratio_float(w & 31, 31);
                o.comp[3] = FLOAT_ONE;
            end
            else if (m_fmt == FMT_RGBA4 || m_fmt == FMT_RGBA6)
            begin
                bits = (m_fmt == FMT_RGBA4) ? 4 : 6;
                mask = (1 << bits) - 1;
                w = rword(rec, 0, (m_fmt == FMT_RGBA4) ? 2 : 3, m_le);
                for (int j = 0; j < 4; j++)
                    o.comp[j] = ratio_float((w >> ((3 - j) * bits)) & mask, mask);
            end
            else
            begin
                for (int j = 0; j < 3; j++)
                    o.comp[j] = ratio_float(rbyte(rec, j), 255);
                o.comp[3] = (m_fmt == FMT_RGB8 || m_fmt == FMT_RGBX8) ? FLOAT_ONE
                          : ratio_float(rbyte(rec, 3), 255);
            end
        end
        else
        begin
            comps = (m_count == 0) ? 3 : m_count;
            outc = m_outc;
            ty = (m_type > TYPE_F32) ? TYPE_U8 : m_type;
            for (int j = 0; j < comps; j++)
            begin
                if (ty == TYPE_F32)
                    o.comp[j] = rword(rec, 4 * j, 4, m_le);
                else
                begin
                    if (ty == TYPE_U8)
                        iv = rbyte(rec, j);
                    else if (ty == TYPE_S8)
                        iv = int'($signed(rbyte(rec, j)));
                    else
                    begin
                        w = rword(rec, 2 * j, 2, m_le);
                        iv = (ty == TYPE_S16) ? int'($signed(w[15:0])) : int'(w[15:0]);
                    end
                    o.comp[j] = int_to_float(iv, m_frac);
                end
            end
            o.count = 3'((comps > outc) ? comps : outc);
        end
        return o;
    endfunction

    task automatic flag(string what, logic [31:0] want, logic [31:0] got);
        failures++;
        if (failures <= 10)
            $display("mismatch %s: expected %h got %h", what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        vertex_out_t e;
        if (!rst_n)
        begin
            m_class = 1'b0;
            m_type = TYPE_U8;
            m_fmt = FMT_RGB565;
            m_count = 2'd3;
            m_outc = 2'd3;
            m_frac = '0;
            m_le = 1'b0;
            expected_q.delete();
            failures = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
                case (cfg_index)
                    REG_CLASS:      m_class = cfg_wdata[0];
                    REG_COMP_TYPE:  m_type = cfg_wdata[2:0];
                    REG_COLOR_FMT:  m_fmt = cfg_wdata[2:0];
                    REG_COMP_COUNT: m_count = cfg_wdata[1:0];
                    REG_OUT_COMPS:  m_outc = cfg_wdata[1:0];
                    REG_FRAC_BITS:  m_frac = cfg_wdata;
                    REG_LITTLE_END: m_le = cfg_wdata[0];
                    default: ;
                endcase
            if (s_axis_tvalid && s_axis_tready)
                expected_q.insert(expected_q.size(), decode_vertex(s_axis_tdata, s_axis_tlast));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_q.size() == 0)
                    flag("unexpected beat", 32'd0, m_axis_tdata[31:0]);
                else
                begin
                    e = expected_q.pop_front();
                    for (int j = 0; j < 4; j++)
                        if (m_axis_tdata[32*j +: 32] !== e.comp[j])
                            flag($sformatf("value_%0d", j), e.comp[j], m_axis_tdata[32*j +: 32]);
                    if (m_axis_tdata[130:128] !== e.count)
                        flag("written_count", 32'(e.count), 32'(m_axis_tdata[130:128]));
                    if (m_axis_tlast !== e.last)
                        flag("last_result", 32'(e.last), 32'(m_axis_tlast));
                end
            end
            pending <= expected_q.size();
        end
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
    import vafd_pkg::*;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [4:0]   cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata = '0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;
    logic         m_axis_tlast;
    int           pending;
    int           failures;

    always #5 clk = ~clk;

    vertex_attribute_format_decoder u_top (.*);

    vafd_checker u_chk (.*);

    task automatic write_reg(logic [2:0] idx, logic [4:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_record(logic [95:0] rec, logic last, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= rec;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [95:0] random_record();
        logic [95:0] r;
        if ($urandom_range(0, 1))
            r = {$urandom, $urandom, $urandom};
        else
            for (int k = 0; k < 12; k++)
                r[8*k +: 8] = pick_byte();
        return r;
    endfunction

    // receiver: random stalls, one long hold-off to back up the pipeline
    initial
    begin
        int cyc;
        int g;
        bit long_done;
        cyc = 0;
        long_done = 1'b0;
        @(posedge rst_n);
        while (1)
        begin
            g = gap_len();
            if (!long_done && cyc > 3000 && s_axis_tvalid)
            begin
                g = 300;
                long_done = 1'b1;
            end
            m_axis_tready <= (g == 0);
            repeat (g > 0 ? g : 1) @(posedge clk);
            cyc += (g > 0 ? g : 1);
            if (g > 0)
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
                cyc++;
            end
        end
    end

    initial
    begin
        logic [95:0] corners [6];
        logic [4:0]  frac;
        corners[0] = '0;
        corners[1] = '1;
        corners[2] = {12{8'h80}};
        corners[3] = {12{8'h7F}};
        corners[4] = {6{16'h0080}};
        corners[5] = {3{32'h7FC0_0001}};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // reset settings first
        for (int i = 0; i < 6; i++)
            send_record(corners[i], i[0], 1'b0);
        for (int p = 0; p < 32; p++)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while (pending != 0)
                @(posedge clk);
            repeat (6) @(posedge clk);
            case (p % 3)
                0: frac = 5'd0;
                1: frac = 5'd31;
                default: frac = 5'($urandom);
            endcase
            write_reg(REG_CLASS, 5'(p % 2));
            write_reg(REG_COMP_TYPE, 5'((p / 2) % 8));
            write_reg(REG_COLOR_FMT, 5'((p / 2) % 8));
            write_reg(REG_COMP_COUNT, 5'(p % 4));
            write_reg(REG_OUT_COMPS, 5'((p / 4) % 4));
            write_reg(REG_FRAC_BITS, frac);
            write_reg(REG_LITTLE_END, 5'((p / 3) % 2));
            if (p < 4)
                for (int i = 0; i < 6; i++)
                    send_record(corners[i], i[0], 1'b1);
            for (int i = 0; i < 40; i++)
                send_record(random_record(), 1'($urandom), p % 5 != 2);
        end
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #10000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
